// File: rtl/core/hsw_pkg.sv
// Shared constants and types for the five-point heat stencil sweep core.
package hsw_pkg;

  localparam int MAX_WIDTH  = 1024;
  localparam int MAX_HEIGHT = 1024;
  localparam int MAX_DIM    = (MAX_WIDTH > MAX_HEIGHT) ? MAX_WIDTH : MAX_HEIGHT;

  localparam int COL_W = $clog2(MAX_WIDTH);
  localparam int ROW_W = $clog2(MAX_HEIGHT);

  // register field widths
  localparam int GRID_W  = 11;
  localparam int ALPHA_W = 15;
  localparam int EPS_W   = 16;
  localparam int DIM_W   = ($clog2(MAX_DIM + 1) > GRID_W) ? $clog2(MAX_DIM + 1) : GRID_W;

  localparam int CELL_W    = 32;
  localparam int OUT_IDX_W = 10;

  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 16;

  localparam int MIN_DIM   = 3;
  localparam int ALPHA_MAX = 16384;
  localparam int ONE_Q16   = 65536;
  localparam int HALF_Q16  = 32768;

  localparam logic [GRID_W-1:0]  GRID_WIDTH_RST  = GRID_W'(1024);
  localparam logic [GRID_W-1:0]  GRID_HEIGHT_RST = GRID_W'(1024);
  localparam logic [ALPHA_W-1:0] ALPHA_RST       = ALPHA_W'(1311);
  localparam logic [EPS_W-1:0]   EPS_RST         = EPS_W'(66);

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_GRID_WIDTH  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_GRID_HEIGHT = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] REG_ALPHA       = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] REG_EPSILON     = CFG_IDX_W'(3);

  typedef logic signed [CELL_W-1:0] cell_t;

  typedef struct packed {
    logic             en;
    logic [COL_W-1:0] addr;
  } hsw_rd_t;

  typedef struct packed {
    logic             en;
    logic [COL_W-1:0] addr;
    cell_t            fresh;
  } hsw_wr_t;

endpackage

// File: rtl/core/hsw_if.sv
// Channel interfaces: cell input, stencil result output, configuration write.
interface hsw_in_if;
  import hsw_pkg::*;
  logic  valid;
  logic  ready;
  cell_t cell_value;
  modport source (output valid, output cell_value, input ready);
  modport sink   (input valid, input cell_value, output ready);
endinterface

interface hsw_out_if;
  import hsw_pkg::*;
  logic                 valid;
  logic                 ready;
  cell_t                new_value;
  logic [OUT_IDX_W-1:0] row_index;
  logic [OUT_IDX_W-1:0] col_index;
  logic                 last_of_grid;
  logic                 converged;
  modport source (output valid, output new_value, output row_index, output col_index,
                  output last_of_grid, output converged, input ready);
  modport sink   (input valid, input new_value, input row_index, input col_index,
                  input last_of_grid, input converged, output ready);
endinterface

interface hsw_cfg_if;
  import hsw_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  reg_index;
  logic [CFG_DATA_W-1:0] wr_data;
  modport source (output valid, output reg_index, output wr_data, input ready);
  modport sink   (input valid, input reg_index, input wr_data, output ready);
endinterface

// File: rtl/core/hsw_row_store.sv
// Upper and middle row stores: one read and one retire write per cycle.
module hsw_row_store
  import hsw_pkg::*;
(
  input  logic    clk,
  input  hsw_rd_t rd,
  input  hsw_wr_t wr,
  output cell_t   mid_q,
  output cell_t   up_q
);

  cell_t mid_mem [MAX_WIDTH];
  cell_t up_mem  [MAX_WIDTH];

  always_ff @(posedge clk) begin
    if (rd.en) begin
      mid_q <= mid_mem[rd.addr];
      up_q  <= up_mem[rd.addr];
    end
  end

  // retire: the old middle entry (still in mid_q) moves up, the fresh cell goes in
  always_ff @(posedge clk) begin
    if (wr.en) begin
      up_mem[wr.addr]  <= mid_q;
      mid_mem[wr.addr] <= wr.fresh;
    end
  end

endmodule

// File: rtl/core/heat_stencil_5pt_sweep_core.sv
// Five-point Jacobi heat stencil over a raster-order grid stream.
// A result passes stage registers s1 to s4 and then the output register after its completing word.
// Throughput: one cell word per cycle unless stalled, set by the row stores' single read/write pair.
// Reset clears counters and pipeline valids, sets the convergence flag and loads the register defaults;
// row store contents stay undefined until written, no clearing pass.
module heat_stencil_5pt_sweep_core
  import hsw_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  hsw_in_if.sink    in_chan,
  hsw_out_if.source out_chan,
  hsw_cfg_if.sink   cfg_chan
);

  // configuration
  logic [GRID_W-1:0]  grid_w_r, grid_h_r;
  logic [ALPHA_W-1:0] alpha_r;
  logic [EPS_W-1:0]   eps_r;

  assign cfg_chan.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      grid_w_r <= GRID_WIDTH_RST;
      grid_h_r <= GRID_HEIGHT_RST;
      alpha_r  <= ALPHA_RST;
      eps_r    <= EPS_RST;
    end else if (cfg_chan.valid) begin
      unique case (cfg_chan.reg_index)
        REG_GRID_WIDTH:  grid_w_r <= cfg_chan.wr_data[GRID_W-1:0];
        REG_GRID_HEIGHT: grid_h_r <= cfg_chan.wr_data[GRID_W-1:0];
        REG_ALPHA:       alpha_r  <= cfg_chan.wr_data[ALPHA_W-1:0];
        REG_EPSILON:     eps_r    <= cfg_chan.wr_data[EPS_W-1:0];
        default: ;
      endcase
    end
  end

  // pipeline handshake
  logic s1_v_r, s2_v_r, s3_v_r, s4_v_r, out_v_r;
  logic s1_emit_r, s2_emit_r, s3_emit_r, s4_emit_r;
  logic s1_gend_r, s2_gend_r, s3_gend_r, s4_gend_r;
  logic out_ok, s4_leave, s4_take, s3_leave, s3_take, s2_leave, s2_take, s1_leave;
  logic in_acc;

  assign out_ok   = !out_v_r || out_chan.ready;
  assign s4_leave = s4_v_r && (!s4_emit_r || out_ok);
  assign s4_take  = !s4_v_r || s4_leave;
  assign s3_leave = s3_v_r && s4_take;
  assign s3_take  = !s3_v_r || s3_leave;
  assign s2_leave = s2_v_r && s3_take;
  assign s2_take  = !s2_v_r || s2_leave;
  // items with no result and no sweep end drop out after the row-store write
  assign s1_leave = s1_v_r && (!(s1_emit_r || s1_gend_r) || s2_take);
  assign in_chan.ready = !s1_v_r || s1_leave;
  assign in_acc   = in_chan.valid && in_chan.ready;

  // position tracking at accept
  logic [COL_W-1:0] col_r, col_nxt;
  logic [ROW_W-1:0] row_r, row_nxt;
  logic [DIM_W-1:0] gw, gh, w_eff, h_eff, wm1, hm1, c_ext, r_ext;
  logic row_end, grid_end, emit, last;

  always_comb begin
    gw    = DIM_W'(grid_w_r);
    gh    = DIM_W'(grid_h_r);
    w_eff = (gw < DIM_W'(MIN_DIM)) ? DIM_W'(MIN_DIM) :
            (gw > DIM_W'(MAX_WIDTH)) ? DIM_W'(MAX_WIDTH) : gw;
    h_eff = (gh < DIM_W'(MIN_DIM)) ? DIM_W'(MIN_DIM) :
            (gh > DIM_W'(MAX_HEIGHT)) ? DIM_W'(MAX_HEIGHT) : gh;
    wm1   = w_eff - DIM_W'(1);
    hm1   = h_eff - DIM_W'(1);
    c_ext = DIM_W'(col_r);
    r_ext = DIM_W'(row_r);
    row_end  = c_ext >= wm1;
    grid_end = row_end && (r_ext >= hm1);
    emit = (r_ext >= DIM_W'(2)) && (r_ext <= hm1) && (c_ext >= DIM_W'(2)) && (c_ext <= wm1);
    last = (r_ext == hm1) && (c_ext == wm1);
    if (grid_end) begin
      col_nxt = '0;
      row_nxt = '0;
    end else if (row_end) begin
      col_nxt = '0;
      row_nxt = row_r + ROW_W'(1);
    end else begin
      col_nxt = col_r + COL_W'(1);
      row_nxt = row_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
    end else if (in_acc) begin
      col_r <= col_nxt;
      row_r <= row_nxt;
    end
  end

  // stage 1: row-store read data arrives
  cell_t                s1_x_r;
  logic [COL_W-1:0]     s1_col_r;
  logic [OUT_IDX_W-1:0] s1_ri_r, s1_ci_r;
  logic                 s1_last_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (in_chan.ready) begin
      s1_v_r <= in_chan.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_x_r    <= in_chan.cell_value;
      s1_col_r  <= col_r;
      s1_emit_r <= emit;
      s1_gend_r <= grid_end;
      s1_last_r <= last;
      s1_ri_r   <= OUT_IDX_W'(r_ext - DIM_W'(1));
      s1_ci_r   <= OUT_IDX_W'(c_ext - DIM_W'(1));
    end
  end

  hsw_rd_t rs_rd;
  hsw_wr_t rs_wr;
  cell_t   mid_q, up_q;

  assign rs_rd.en    = in_acc;
  assign rs_rd.addr  = col_r;
  assign rs_wr.en    = s1_leave;
  assign rs_wr.addr  = s1_col_r;
  assign rs_wr.fresh = s1_x_r;

  hsw_row_store u_rows (
    .clk   (clk),
    .rd    (rs_rd),
    .wr    (rs_wr),
    .mid_q (mid_q),
    .up_q  (up_q)
  );

  // column history of the current row: x1 = south, mid1 = center, mid2 = west, up1 = north
  cell_t x1_r, mid1_r, mid2_r, up1_r;

  always_ff @(posedge clk) begin
    if (s1_leave) begin
      x1_r   <= s1_x_r;
      mid1_r <= mid_q;
      mid2_r <= mid1_r;
      up1_r  <= up_q;
    end
  end

  logic signed [CELL_W+1:0] nb;
  assign nb = {{2{up1_r[CELL_W-1]}}, up1_r} + {{2{mid2_r[CELL_W-1]}}, mid2_r}
            + {{2{mid_q[CELL_W-1]}}, mid_q} + {{2{x1_r[CELL_W-1]}}, x1_r};

  // stage 2: neighbor sum
  logic signed [CELL_W+1:0] s2_nb_r;
  cell_t                    s2_ctr_r, s3_ctr_r, s4_ctr_r;
  logic [OUT_IDX_W-1:0]     s2_ri_r, s2_ci_r, s3_ri_r, s3_ci_r, s4_ri_r, s4_ci_r;
  logic                     s2_last_r, s3_last_r, s4_last_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_v_r <= 1'b0;
    end else if (s2_take) begin
      s2_v_r <= s1_v_r && (s1_emit_r || s1_gend_r);
    end
  end

  always_ff @(posedge clk) begin
    if (s2_take) begin
      s2_nb_r   <= nb;
      s2_ctr_r  <= mid1_r;
      s2_emit_r <= s1_emit_r;
      s2_gend_r <= s1_gend_r;
      s2_last_r <= s1_last_r;
      s2_ri_r   <= s1_ri_r;
      s2_ci_r   <= s1_ci_r;
    end
  end

  // stage 3: coefficient products
  logic [ALPHA_W-1:0]       a_eff;
  logic [ALPHA_W+1:0]       k_eff;
  logic signed [49:0]       p1, p2;
  logic signed [49:0]       s3_p1_r, s3_p2_r;

  assign a_eff = (alpha_r > ALPHA_W'(ALPHA_MAX)) ? ALPHA_W'(ALPHA_MAX) : alpha_r;
  assign k_eff = (ALPHA_W+2)'(ONE_Q16) - {a_eff, 2'b00};
  assign p1    = $signed({1'b0, a_eff}) * s2_nb_r;
  assign p2    = $signed({1'b0, k_eff}) * s2_ctr_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_v_r <= 1'b0;
    end else if (s3_take) begin
      s3_v_r <= s2_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s3_take) begin
      s3_p1_r   <= p1;
      s3_p2_r   <= p2;
      s3_ctr_r  <= s2_ctr_r;
      s3_emit_r <= s2_emit_r;
      s3_gend_r <= s2_gend_r;
      s3_last_r <= s2_last_r;
      s3_ri_r   <= s2_ri_r;
      s3_ci_r   <= s2_ci_r;
    end
  end

  // stage 4: sum, round half up, saturate
  logic signed [50:0] acc;
  logic signed [34:0] shr;
  cell_t              v_sat, s4_v_cell_r;

  always_comb begin
    acc = {s3_p1_r[49], s3_p1_r} + {s3_p2_r[49], s3_p2_r} + 51'(HALF_Q16);
    shr = acc[50:16];
    if (!shr[34] && (|shr[33:31])) begin
      v_sat = {1'b0, {(CELL_W-1){1'b1}}};
    end else if (shr[34] && !(&shr[33:31])) begin
      v_sat = {1'b1, {(CELL_W-1){1'b0}}};
    end else begin
      v_sat = shr[CELL_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s4_v_r <= 1'b0;
    end else if (s4_take) begin
      s4_v_r <= s3_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s4_take) begin
      s4_v_cell_r <= v_sat;
      s4_ctr_r    <= s3_ctr_r;
      s4_emit_r   <= s3_emit_r;
      s4_gend_r   <= s3_gend_r;
      s4_last_r   <= s3_last_r;
      s4_ri_r     <= s3_ri_r;
      s4_ci_r     <= s3_ci_r;
    end
  end

  // output: change check against epsilon and sweep-wide convergence flag
  logic signed [CELL_W:0] diff, eps_s;
  logic                   exceed, sc_r, sc_eff, sc_nxt;

  always_comb begin
    diff   = {s4_v_cell_r[CELL_W-1], s4_v_cell_r} - {s4_ctr_r[CELL_W-1], s4_ctr_r};
    eps_s  = $signed({{(CELL_W+1-EPS_W){1'b0}}, eps_r});
    exceed = (diff > eps_s) || (diff < -eps_s);
    sc_eff = sc_r && !(s4_emit_r && exceed);
    sc_nxt = s4_gend_r ? 1'b1 : sc_eff;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sc_r <= 1'b1;
    end else if (s4_leave) begin
      sc_r <= sc_nxt;
    end
  end

  cell_t                out_val_r;
  logic [OUT_IDX_W-1:0] out_ri_r, out_ci_r;
  logic                 out_last_r, out_conv_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (out_ok) begin
      out_v_r <= s4_leave && s4_emit_r;
    end
  end

  always_ff @(posedge clk) begin
    if (out_ok && s4_leave && s4_emit_r) begin
      out_val_r  <= s4_v_cell_r;
      out_ri_r   <= s4_ri_r;
      out_ci_r   <= s4_ci_r;
      out_last_r <= s4_last_r;
      out_conv_r <= s4_last_r && sc_eff;
    end
  end

  assign out_chan.valid        = out_v_r;
  assign out_chan.new_value    = out_val_r;
  assign out_chan.row_index    = out_ri_r;
  assign out_chan.col_index    = out_ci_r;
  assign out_chan.last_of_grid = out_last_r;
  assign out_chan.converged    = out_conv_r;

  // checks
  a_rs_no_collide: assert property (@(posedge clk) disable iff (!rst_n)
    (rs_rd.en && rs_wr.en) |-> (rs_rd.addr != rs_wr.addr))
    else $error("row store read and retire hit the same column");

  a_conv_only_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r |-> (!out_conv_r || out_last_r))
    else $error("converged raised on a word that is not last of grid");

  a_col_step: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && !row_end) |=> (col_r == $past(col_r) + COL_W'(1)))
    else $error("column position did not advance");

  a_sweep_reset: assert property (@(posedge clk) disable iff (!rst_n)
    (s4_leave && s4_gend_r) |=> sc_r)
    else $error("convergence flag not rearmed at sweep end");

endmodule

// File: bench/heat_stencil_5pt_sweep_core_tb.sv
// Self-checking testbench for the five-point heat stencil sweep core.
module heat_stencil_5pt_sweep_core_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import hsw_pkg::*;

  typedef struct {
    cell_t                new_value;
    logic [OUT_IDX_W-1:0] row_index;
    logic [OUT_IDX_W-1:0] col_index;
    logic                 last_of_grid;
    logic                 converged;
  } stencil_result_t;

  typedef enum {FILL_NOISE, FILL_SMOOTH, FILL_FLAT, FILL_RAILS} fill_kind_e;

  localparam cell_t CELL_MAX = 32'sh7FFF_FFFF;
  localparam cell_t CELL_MIN = 32'sh8000_0000;

  logic clk;
  logic rst_n;

  hsw_in_if  in_if ();
  hsw_out_if out_if ();
  hsw_cfg_if cfg_if ();

  heat_stencil_5pt_sweep_core DUT (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_if),
    .out_chan (out_if),
    .cfg_chan (cfg_if)
  );

  // predicted results, oldest first
  stencil_result_t grid_results[$];
  int errors;

  // shadow of the block: registers, row stores, window and sweep position
  logic [GRID_W-1:0]  width_reg;
  logic [GRID_W-1:0]  height_reg;
  logic [ALPHA_W-1:0] alpha_reg;
  logic [EPS_W-1:0]   eps_reg;
  cell_t above_row [MAX_WIDTH];
  cell_t center_row [MAX_WIDTH];
  cell_t recent_cells [3];
  int    col_pos;
  int    row_pos;
  bit    sweep_calm;

  fill_kind_e fill_kind;
  int         fill_base;
  int         fill_spread;

  int burst_left;
  int hold_ask;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #3_600_000;
    $display("heat_stencil_5pt_sweep_core_tb: done, errors");
    $finish;
  end

  function automatic int clamp_int(int v, int lo, int hi);
    if (v < lo) return lo;
    if (v > hi) return hi;
    return v;
  endfunction

  function automatic void retire_col(int col, cell_t fresh);
    above_row[col] = center_row[col];
    center_row[col] = fresh;
  endfunction

  function automatic void advance_stencil(cell_t x);
    int w, h, c, r;
    longint a, nb, ctr, v, d;
    bit row_end, grid_end;
    stencil_result_t res;
    w = clamp_int(int'(width_reg), MIN_DIM, MAX_WIDTH);
    h = clamp_int(int'(height_reg), MIN_DIM, MAX_HEIGHT);
    a = clamp_int(int'(alpha_reg), 0, ALPHA_MAX);
    c = col_pos;
    r = row_pos;
    row_end = (c >= w - 1);
    grid_end = row_end && (r >= h - 1);
    if (r >= 2 && r <= h - 1 && c >= 2 && c <= w - 1) begin
      nb = longint'(above_row[c-1]) + longint'(center_row[c-2])
         + longint'(center_row[c]) + longint'(recent_cells[0]);
      ctr = longint'(center_row[c-1]);
      // exact Q.32 sum, round half up, back to Q16.16
      v = (a * nb + (ONE_Q16 - 4 * a) * ctr + HALF_Q16) >>> 16;
      if (v > longint'(CELL_MAX)) v = longint'(CELL_MAX);
      if (v < longint'(CELL_MIN)) v = longint'(CELL_MIN);
      d = v - ctr;
      if (d < 0) d = -d;
      if (d > longint'(eps_reg)) sweep_calm = 1'b0;
      res.new_value    = cell_t'(v);
      res.row_index    = OUT_IDX_W'(r - 1);
      res.col_index    = OUT_IDX_W'(c - 1);
      res.last_of_grid = (r == h - 1) && (c == w - 1);
      res.converged    = res.last_of_grid && sweep_calm;
      grid_results.push_back(res);
    end
    // column c-2 is done with; at row end the last two columns go too
    if (c >= 2) retire_col(c - 2, recent_cells[1]);
    if (row_end) begin
      if (c >= 1) retire_col(c - 1, recent_cells[0]);
      retire_col(c, x);
    end
    recent_cells[2] = recent_cells[1];
    recent_cells[1] = recent_cells[0];
    recent_cells[0] = x;
    if (grid_end) begin
      col_pos = 0;
      row_pos = 0;
      sweep_calm = 1'b1;
    end else if (row_end) begin
      col_pos = 0;
      row_pos = r + 1;
    end else begin
      col_pos = c + 1;
    end
  endfunction

  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
      errors++;
    end
  endfunction

  stencil_result_t want;

  always @(posedge clk) begin
    if (rst_n && out_if.valid === 1'b1 && out_if.ready === 1'b1) begin
      if (grid_results.size() == 0) begin
        $display("%0t: unexpected word, row %0d col %0d value %h", $time,
                 out_if.row_index, out_if.col_index, out_if.new_value);
        errors++;
      end else begin
        want = grid_results.pop_front();
        check_field("new_value", want.new_value, out_if.new_value);
        check_field("row_index", want.row_index, out_if.row_index);
        check_field("col_index", want.col_index, out_if.col_index);
        check_field("last_of_grid", want.last_of_grid, out_if.last_of_grid);
        check_field("converged", want.converged, out_if.converged);
      end
    end
  end

  // result side: stall pattern in phases, plus long hold-offs on request
  initial begin : drain_side
    int phase_left;
    int stall_pct;
    int hold_left;
    phase_left = 0;
    stall_pct = 0;
    hold_left = 0;
    out_if.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_ask > 0) begin
        hold_left = hold_ask;
        hold_ask = 0;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_if.ready <= 1'b0;
      end else begin
        if (phase_left == 0) begin
          phase_left = $urandom_range(8, 80);
          case ($urandom_range(0, 4))
            0, 1:    stall_pct = 0;
            2:       stall_pct = 20;
            3:       stall_pct = 50;
            default: stall_pct = 85;
          endcase
        end
        phase_left--;
        out_if.ready <= ($urandom_range(0, 99) >= stall_pct);
      end
    end
  end

  // one cell word, sent in bursts with random gaps; caller sits at a falling edge
  task automatic send_cell(cell_t v);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      if ($urandom_range(0, 3) != 0) begin
        in_if.valid <= 1'b0;
        repeat (($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 4))
          @(negedge clk);
      end
    end
    burst_left--;
    in_if.valid      <= 1'b1;
    in_if.cell_value <= v;
    do @(posedge clk); while (in_if.ready !== 1'b1);
    advance_stencil(v);
    @(negedge clk);
  endtask

  // wait until every predicted word is out, then let the pipeline empty
  task automatic settle();
    in_if.valid <= 1'b0;
    while (grid_results.size() != 0) @(negedge clk);
    repeat (12) @(negedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    cfg_if.valid     <= 1'b1;
    cfg_if.reg_index <= idx;
    cfg_if.wr_data   <= data;
    do @(posedge clk); while (cfg_if.ready !== 1'b1);
    case (idx)
      REG_GRID_WIDTH:  width_reg  = data[GRID_W-1:0];
      REG_GRID_HEIGHT: height_reg = data[GRID_W-1:0];
      REG_ALPHA:       alpha_reg  = data[ALPHA_W-1:0];
      REG_EPSILON:     eps_reg    = data[EPS_W-1:0];
      default: ;
    endcase
    @(negedge clk);
  endtask

  task automatic program_regs(logic [CFG_DATA_W-1:0] w, logic [CFG_DATA_W-1:0] h,
                              logic [CFG_DATA_W-1:0] a, logic [CFG_DATA_W-1:0] e);
    settle();
    write_reg(REG_GRID_WIDTH, w);
    write_reg(REG_GRID_HEIGHT, h);
    write_reg(REG_ALPHA, a);
    write_reg(REG_EPSILON, e);
    cfg_if.valid <= 1'b0;
  endtask

  function automatic logic [CFG_DATA_W-1:0] pick_alpha();
    case ($urandom_range(0, 5))
      0:       return 0;
      1:       return ALPHA_MAX;
      2:       return $urandom_range(ALPHA_MAX + 1, 16'hFFFF);
      default: return $urandom_range(0, ALPHA_MAX);
    endcase
  endfunction

  function automatic logic [CFG_DATA_W-1:0] pick_eps();
    case ($urandom_range(0, 4))
      0:       return 0;
      1:       return 16'hFFFF;
      2:       return $urandom_range(0, 65535);
      default: return $urandom_range(0, 200);
    endcase
  endfunction

  function automatic void choose_fill();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 45)      fill_kind = FILL_SMOOTH;
    else if (roll < 75) fill_kind = FILL_NOISE;
    else if (roll < 85) fill_kind = FILL_FLAT;
    else                fill_kind = FILL_RAILS;
    fill_base = int'($urandom_range(0, 32'h01FF_FFFF)) - 32'h0100_0000;
    // small spread keeps changes under a typical threshold
    fill_spread = ($urandom_range(0, 1) == 0) ? $urandom_range(1, 40) : $urandom_range(500, 5000);
  endfunction

  function automatic cell_t next_cell();
    case (fill_kind)
      FILL_NOISE:  return cell_t'($urandom);
      FILL_SMOOTH: return cell_t'(fill_base + int'($urandom_range(0, 2 * fill_spread))
                                  - fill_spread);
      FILL_FLAT:   return cell_t'(fill_base);
      default:     return ($urandom_range(0, 1) == 1) ? CELL_MAX : CELL_MIN;
    endcase
  endfunction

  // runs from the current position to the end of the sweep
  task automatic feed_sweep(inout int sent);
    do begin
      send_cell(next_cell());
      sent++;
    end while (col_pos != 0 || row_pos != 0);
  endtask

  task automatic test_smallest_grid();
    // width field 1 and height 2 clamp to 3; junk above the width field
    program_regs(16'hF801, 16'h0002, ALPHA_MAX, 16'hFFFF);
    for (int i = 0; i < 9; i++) send_cell((i == 4) ? CELL_MIN : CELL_MAX);
  endtask

  task automatic test_coefficient_extremes();
    // zero alpha leaves the center as is, so zero epsilon still converges
    program_regs(3, 3, 0, 0);
    repeat (9) send_cell(cell_t'($urandom));
    // all-ones alpha clamps to a quarter: center drops out
    program_regs(3, 3, 16'hFFFF, 0);
    for (int i = 0; i < 9; i++) send_cell((i % 2 == 1) ? CELL_MIN : CELL_MAX);
  endtask

  task automatic test_widest_grid();
    int sent;
    sent = 0;
    // 2047 clamps to full width, height field 0 clamps to 3
    program_regs(16'h07FF, 16'h0800, pick_alpha(), pick_eps());
    choose_fill();
    feed_sweep(sent);
  endtask

  task automatic test_tallest_grid();
    int sent;
    sent = 0;
    program_regs(0, 16'hFFFF, pick_alpha(), pick_eps());
    choose_fill();
    feed_sweep(sent);
  endtask

  task automatic test_output_backpressure();
    int sent;
    sent = 0;
    program_regs(24, 24, pick_alpha(), pick_eps());
    fill_kind = FILL_NOISE;
    hold_ask = 400;
    feed_sweep(sent);
  endtask

  task automatic test_random_sweeps();
    int sent, w, h, cut_rows;
    sent = 0;
    while (sent < 1050) begin
      w = ($urandom_range(0, 9) == 0) ? $urandom_range(17, 64) : $urandom_range(3, 16);
      h = $urandom_range(3, 12);
      program_regs(w, h, pick_alpha(), pick_eps());
      choose_fill();
      // now and then stop at a row boundary and shrink the grid mid-sweep
      if (h >= 5 && $urandom_range(0, 5) == 0) begin
        cut_rows = $urandom_range(2, h - 2);
        repeat (cut_rows * w) begin
          send_cell(next_cell());
          sent++;
        end
        program_regs($urandom_range(3, w), $urandom_range(3, h), pick_alpha(), pick_eps());
      end
      feed_sweep(sent);
    end
  endtask

  initial begin : run_tests
    errors = 0;
    burst_left = 0;
    hold_ask = 0;
    rst_n = 1'b0;
    in_if.valid = 1'b0;
    in_if.cell_value = '0;
    cfg_if.valid = 1'b0;
    cfg_if.reg_index = '0;
    cfg_if.wr_data = '0;
    width_reg = GRID_WIDTH_RST;
    height_reg = GRID_HEIGHT_RST;
    alpha_reg = ALPHA_RST;
    eps_reg = EPS_RST;
    foreach (recent_cells[i]) recent_cells[i] = '0;
    col_pos = 0;
    row_pos = 0;
    sweep_calm = 1'b1;
    fill_kind = FILL_NOISE;
    fill_base = 0;
    fill_spread = 1;
    repeat (5) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    test_smallest_grid();
    test_coefficient_extremes();
    test_widest_grid();
    test_tallest_grid();
    test_output_backpressure();
    test_random_sweeps();

    settle();
    if (errors == 0) begin
      $display("heat_stencil_5pt_sweep_core_tb: done, clean");
    end else begin
      $display("heat_stencil_5pt_sweep_core_tb: done, errors");
    end
    $finish;
  end

endmodule
